@@ sv/sas_pkg.sv @@
// Shared types and constants for the steering agent step core.
package sas_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] NearInit = 32'(64'd10000 << FracBits);

  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FORCE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SEP_GAIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SEEK_GAIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_START_X   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_START_Y   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_START_Z   = 3'd7;

  typedef enum logic [1:0] {
    KIND_NEIGHBOUR = 2'd0,
    KIND_TARGET    = 2'd1,
    KIND_TICK      = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
  } res_t;

endpackage

@@ sv/steering_agent_step_core.sv @@
// Top level of the steering agent step core: separation plus seek in Q16.16.
//
// Channels: the input channel (in_valid_i/in_ready_o) carries neighbour,
// target and tick items; the output channel (out_valid_o/out_ready_i) carries
// one position/velocity result per tick. The configuration channel takes one
// register write per transfer and is always ready; write only while idle.
// Items first land in a two-entry queue, then a sequencer works them one at a
// time on a shared 32x32 multiplier, a 64-step divider and a 32-step root.
// Work per item: a neighbour takes three 64-step divides, a target a root
// plus a normalize shift, a tick up to five vector lengths and scalings,
// each scaling three divides. Kind 3 is dropped at the input. Reset loads
// the default registers, zero position, velocity and sums, and an empty
// queue. A stalled receiver holds the result register; items still queue
// and non-tick items keep being processed until the next tick needs the
// result register.
module steering_agent_step_core import sas_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic signed [31:0]  px_i,
  input  logic signed [31:0]  py_i,
  input  logic signed [31:0]  pz_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [31:0]  vel_x_o,
  output logic signed [31:0]  vel_y_o,
  output logic signed [31:0]  vel_z_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  item_t   item;
  logic    item_valid, item_ready;
  cfg_wr_t cfg;
  res_t    res;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  sas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .px_i         (px_i),
    .py_i         (py_i),
    .pz_i         (pz_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  sas_back #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign pos_x_o = res.pos[0];
  assign pos_y_o = res.pos[1];
  assign pos_z_o = res.pos[2];
  assign vel_x_o = res.vel[0];
  assign vel_y_o = res.vel[1];
  assign vel_z_o = res.vel[2];

endmodule

@@ sv/sas_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit operands.
module sas_div import sas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] sh, diff;
  logic        ge;

  assign sh     = {rem_q, quo_q[63]};
  assign ge     = sh >= {1'b0, den_q};
  assign diff   = sh - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= num_i;
        den_q  <= den_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[63:0] : sh[63:0];
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/sas_sqrt.sv @@
// Bit-pair integer square root, one result bit per cycle.
module sas_sqrt import sas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, r_q, b_q, rb;
  logic        busy_q, done_q, ge;

  assign rb     = r_q + b_q;
  assign ge     = x_q >= rb;
  assign done_o = done_q;
  assign root_o = r_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      x_q    <= '0;
      r_q    <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= {2'b00, rad_i};
        r_q    <= '0;
        b_q    <= 64'h4000_0000_0000_0000;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          x_q <= x_q - rb;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
        if (b_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/sas_front.sv @@
// Input side: accepts items, drops unused kinds, queues them for the sequencer.
module sas_front import sas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               item_ready_i
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            known, push, pop;
  item_t           wr_item;

  always_comb begin
    unique case (kind_i) inside
      KIND_NEIGHBOUR, KIND_TARGET, KIND_TICK: known = 1'b1;
      default:                                known = 1'b0;
    endcase
  end

  assign in_ready_o   = cnt_q != CntW'(QueueDepth);
  assign item_valid_o = cnt_q != '0;
  assign item_o       = mem_q[rp_q];
  assign push         = in_valid_i & in_ready_o & known;
  assign pop          = item_valid_o & item_ready_i;

  always_comb begin
    wr_item.kind = kind_e'(kind_i);
    wr_item.px   = px_i;
    wr_item.py   = py_i;
    wr_item.pz   = pz_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + PtrW'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

@@ sv/sas_back.sv @@
// Sequencer: agent state, shared multiplier, divider and root, result register.
module sas_back import sas_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_ready_o,
  input  cfg_wr_t cfg_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output res_t    res_o
);

  localparam int unsigned CntW = $clog2(MAX_NEIGHBOURS + 1);
  localparam logic signed [49:0] Sat48Hi = 50'sd140737488355327;
  localparam logic signed [49:0] Sat48Lo = -50'sd140737488355328;
  localparam logic signed [40:0] Sat32Hi = 41'sd2147483647;
  localparam logic signed [40:0] Sat32Lo = -41'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE, S_NCHK, S_NCHK2, S_NDIVS, S_NDIVW, S_TUPD,
    S_KSEP, S_KSEPG, S_KSEPG2, S_KSEEK, S_KSKG, S_KSKG2, S_KMOVE, S_KOUT,
    S_VRED, S_VSHF, S_VSQ, S_VBR, S_VSQS, S_VSQW, S_VSCL, S_VSCLD, S_VSCLW, S_VRET
  } state_e;

  typedef enum logic [1:0] {M_SUMSQ, M_LEN, M_NORM, M_LIMIT} mode_e;

  typedef enum logic [2:0] {
    P_NEIGH, P_TGT, P_SEP1, P_SEP2, P_SEEK1, P_SEEK2, P_VEL
  } ph_e;

  function automatic logic [47:0] mag49(input logic signed [48:0] x);
    mag49 = x[48] ? 48'(-x) : 48'(x);
  endfunction

  function automatic logic [39:0] mag40(input logic signed [39:0] x);
    mag40 = x[39] ? 40'(-x) : 40'(x);
  endfunction

  function automatic logic [24:0] mag25(input logic signed [24:0] x);
    mag25 = x[24] ? 25'(-x) : 25'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
    if (x > Sat32Hi) sat32 = 32'sh7FFF_FFFF;
    else if (x < Sat32Lo) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x > Sat48Hi) sat48 = Sat48Hi[47:0];
    else if (x < Sat48Lo) sat48 = Sat48Lo[47:0];
    else sat48 = x[47:0];
  endfunction

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  ph_e    ph_q, ph_d;
  logic [2:0] idx_q, idx_d;
  logic signed [48:0] v_q [3], v_d [3];
  logic [47:0] m_q [3], m_d [3];
  logic [4:0]  s_q, s_d;
  logic [61:0] acc_q, acc_d;
  logic [49:0] lsq_q, lsq_d;
  logic [31:0] n_q, n_d;
  logic [24:0] len_q, len_d;
  logic signed [31:0] p_q [3], p_d [3];
  logic signed [31:0] pos_q [3], pos_d [3];
  logic signed [31:0] vel_q [3], vel_d [3];
  logic signed [47:0] psum_q [3], psum_d [3];
  logic [CntW-1:0] pcnt_q, pcnt_d;
  logic signed [31:0] tgt_q [3], tgt_d [3];
  logic [31:0] near_q, near_d;
  logic seen_q, seen_d;
  logic signed [39:0] sep_q [3], sep_d [3];
  logic signed [39:0] sk_q [3], sk_d [3];
  res_t res_q, res_d;
  logic oval_q, oval_d;
  logic [23:0] ms_q, ms_d, mf_q, mf_d, rad_q, rad_d;
  logic signed [24:0] sgain_q, sgain_d, kgain_q, kgain_d;
  logic [63:0] prod_q;
  logic [31:0] mul_a, mul_b;

  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [63:0] div_num, div_den, div_quo;
  logic [31:0] sqrt_root;

  sas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  sas_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign item_ready_o = state_q == S_IDLE;
  assign out_valid_o  = oval_q;
  assign res_o        = res_q;

  always_comb begin
    logic [24:0] two_r;
    logic        rej;
    logic [63:0] q;
    logic [32:0] t;
    logic signed [49:0] st;
    logic [49:0] tdist;
    logic signed [31:0] nv;
    logic signed [31:0] pin [3];

    state_d = state_q; mode_d = mode_q; ph_d = ph_q; idx_d = idx_q;
    v_d = v_q; m_d = m_q; s_d = s_q; acc_d = acc_q; lsq_d = lsq_q; n_d = n_q;
    len_d = len_q; p_d = p_q; pos_d = pos_q; vel_d = vel_q; psum_d = psum_q;
    pcnt_d = pcnt_q; tgt_d = tgt_q; near_d = near_q; seen_d = seen_q;
    sep_d = sep_q; sk_d = sk_q; res_d = res_q;
    ms_d = ms_q; mf_d = mf_q; rad_d = rad_q; sgain_d = sgain_q; kgain_d = kgain_q;
    oval_d = oval_q & ~out_ready_i;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    sqrt_start = 1'b0;
    two_r = {rad_q, 1'b0};
    rej = 1'b0; q = '0; t = '0; st = '0; tdist = '0; nv = '0;
    pin[0] = item_i.px; pin[1] = item_i.py; pin[2] = item_i.pz;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          for (int i = 0; i < 3; i++) begin
            p_d[i] = pin[i];
            v_d[i] = 49'(pos_q[i]) - 49'(pin[i]);
          end
          unique case (item_i.kind)
            KIND_NEIGHBOUR: state_d = S_NCHK;
            KIND_TARGET: begin
              mode_d = M_LEN; ph_d = P_TGT; state_d = S_VRED;
            end
            KIND_TICK: state_d = S_KSEP;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_NCHK: begin
        rej = pcnt_q >= CntW'(MAX_NEIGHBOURS);
        for (int i = 0; i < 3; i++) begin
          if (mag49(v_q[i]) >= 48'(two_r)) rej = 1'b1;
        end
        if (rej) begin
          state_d = S_IDLE;
        end else begin
          len_d = two_r; mode_d = M_SUMSQ; ph_d = P_NEIGH; state_d = S_VRED;
        end
      end
      S_NCHK2: begin
        if (acc_q == '0 || acc_q >= 62'(lsq_q)) begin
          state_d = S_IDLE;
        end else begin
          idx_d = '0; state_d = S_NDIVS;
        end
      end
      S_NDIVS: begin
        div_start = 1'b1;
        div_num = {m_q[idx_q[1:0]][31:0], 32'd0};
        div_den = 64'(acc_q);
        state_d = S_NDIVW;
      end
      S_NDIVW: begin
        if (div_done) begin
          t = div_quo[32:0];
          st = v_q[idx_q[1:0]][48] ? -50'(t) : 50'(t);
          psum_d[idx_q[1:0]] = sat48(50'(psum_q[idx_q[1:0]]) + st);
          if (idx_q == 3'd2) begin
            pcnt_d = pcnt_q + CntW'(1);
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
            state_d = S_NDIVS;
          end
        end
      end
      S_TUPD: begin
        tdist = 50'(n_q) << s_q;
        if (tdist < 50'(near_q)) begin
          near_d = tdist[31:0];
          tgt_d = p_q;
        end else if (!seen_q) begin
          tgt_d = p_q;
        end
        seen_d = 1'b1;
        state_d = S_IDLE;
      end
      S_KSEP: begin
        if (pcnt_q == '0) begin
          for (int i = 0; i < 3; i++) sep_d[i] = '0;
          state_d = S_KSEEK;
        end else begin
          for (int i = 0; i < 3; i++) v_d[i] = 49'(psum_q[i]);
          len_d = {1'b0, ms_q}; mode_d = M_NORM; ph_d = P_SEP1; state_d = S_VRED;
        end
      end
      S_KSEPG: begin
        mul_a = 32'(mag40(sep_q[1]));
        mul_b = 32'(mag25(sgain_q));
        state_d = S_KSEPG2;
      end
      S_KSEPG2: begin
        q = prod_q >> FracBits;
        sep_d[1] = (sep_q[1][39] ^ sgain_q[24]) ? -40'(q) : 40'(q);
        state_d = S_KSEEK;
      end
      S_KSEEK: begin
        if (!seen_q) begin
          for (int i = 0; i < 3; i++) sk_d[i] = '0;
          state_d = S_KMOVE;
        end else begin
          for (int i = 0; i < 3; i++) v_d[i] = 49'(tgt_q[i]) - 49'(pos_q[i]);
          len_d = {1'b0, ms_q}; mode_d = M_NORM; ph_d = P_SEEK1; state_d = S_VRED;
        end
      end
      S_KSKG: begin
        mul_a = 32'(mag40(sk_q[1]));
        mul_b = 32'(mag25(kgain_q));
        state_d = S_KSKG2;
      end
      S_KSKG2: begin
        q = prod_q >> FracBits;
        sk_d[1] = (sk_q[1][39] ^ kgain_q[24]) ? -40'(q) : 40'(q);
        state_d = S_KMOVE;
      end
      S_KMOVE: begin
        for (int i = 0; i < 3; i++) begin
          nv = sat32(41'(vel_q[i]) + 41'(sep_q[i]) + 41'(sk_q[i]));
          vel_d[i] = nv;
          pos_d[i] = sat32(41'(pos_q[i]) + 41'(nv));
          v_d[i] = 49'(nv);
        end
        len_d = {1'b0, ms_q}; mode_d = M_LIMIT; ph_d = P_VEL; state_d = S_VRED;
      end
      S_KOUT: begin
        if (!oval_q || out_ready_i) begin
          for (int i = 0; i < 3; i++) begin
            res_d.pos[i] = pos_q[i];
            res_d.vel[i] = vel_q[i];
            psum_d[i] = '0;
            tgt_d[i] = '0;
          end
          oval_d = 1'b1;
          pcnt_d = '0;
          near_d = NearInit;
          seen_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_VRED: begin
        for (int i = 0; i < 3; i++) m_d[i] = mag49(v_q[i]);
        s_d = '0; acc_d = '0; idx_d = '0;
        state_d = S_VSHF;
      end
      S_VSHF: begin
        if ((m_q[0][47:30] | m_q[1][47:30] | m_q[2][47:30]) != '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
          s_d = s_q + 5'd1;
        end else begin
          state_d = S_VSQ;
        end
      end
      S_VSQ: begin
        if (idx_q < 3'd3) begin
          mul_a = m_q[idx_q[1:0]][31:0];
          mul_b = m_q[idx_q[1:0]][31:0];
        end else begin
          mul_a = 32'(len_q);
          mul_b = 32'(len_q);
        end
        if (idx_q != 3'd0 && idx_q != 3'd4) acc_d = acc_q + prod_q[61:0];
        if (idx_q == 3'd4) begin
          lsq_d = prod_q[49:0];
          state_d = S_VBR;
        end
        idx_d = idx_q + 3'd1;
      end
      S_VBR: begin
        unique case (mode_q)
          M_SUMSQ: state_d = S_VRET;
          M_LIMIT: state_d = (s_q == '0 && acc_q <= 62'(lsq_q)) ? S_VRET : S_VSQS;
          default: state_d = S_VSQS;
        endcase
      end
      S_VSQS: begin
        sqrt_start = 1'b1;
        state_d = S_VSQW;
      end
      S_VSQW: begin
        if (sqrt_done) begin
          n_d = sqrt_root;
          idx_d = '0;
          state_d = (mode_q == M_LEN) ? S_VRET : S_VSCL;
        end
      end
      S_VSCL: begin
        if (n_q == '0) begin
          for (int i = 0; i < 3; i++) v_d[i] = '0;
          state_d = S_VRET;
        end else begin
          mul_a = m_q[idx_q[1:0]][31:0];
          mul_b = 32'(len_q);
          state_d = S_VSCLD;
        end
      end
      S_VSCLD: begin
        div_start = 1'b1;
        div_num = prod_q;
        div_den = 64'(n_q);
        state_d = S_VSCLW;
      end
      S_VSCLW: begin
        if (div_done) begin
          v_d[idx_q[1:0]] = v_q[idx_q[1:0]][48] ? -49'(div_quo[24:0]) : 49'(div_quo[24:0]);
          if (idx_q == 3'd2) begin
            state_d = S_VRET;
          end else begin
            idx_d = idx_q + 3'd1;
            state_d = S_VSCL;
          end
        end
      end
      S_VRET: begin
        unique case (ph_q)
          P_NEIGH: state_d = S_NCHK2;
          P_TGT:   state_d = S_TUPD;
          P_SEP1, P_SEEK1: begin
            for (int i = 0; i < 3; i++) v_d[i] = v_q[i] - 49'(vel_q[i]);
            len_d = {1'b0, mf_q};
            mode_d = M_LIMIT;
            ph_d = (ph_q == P_SEP1) ? P_SEP2 : P_SEEK2;
            state_d = S_VRED;
          end
          P_SEP2: begin
            for (int i = 0; i < 3; i++) sep_d[i] = 40'(v_q[i]);
            state_d = S_KSEPG;
          end
          P_SEEK2: begin
            for (int i = 0; i < 3; i++) sk_d[i] = 40'(v_q[i] + v_q[i] + v_q[i]);
            state_d = S_KSKG;
          end
          P_VEL: begin
            for (int i = 0; i < 3; i++) vel_d[i] = v_q[i][31:0];
            state_d = S_KOUT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAX_SPEED: ms_d = cfg_i.data[23:0];
        CFG_MAX_FORCE: mf_d = cfg_i.data[23:0];
        CFG_RADIUS:    rad_d = cfg_i.data[23:0];
        CFG_SEP_GAIN:  sgain_d = cfg_i.data[24:0];
        CFG_SEEK_GAIN: kgain_d = cfg_i.data[24:0];
        CFG_START_X:   pos_d[0] = cfg_i.data;
        CFG_START_Y:   pos_d[1] = cfg_i.data;
        CFG_START_Z:   pos_d[2] = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_SUMSQ;
      ph_q    <= P_NEIGH;
      idx_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        v_q[i]    <= '0;
        m_q[i]    <= '0;
        p_q[i]    <= '0;
        pos_q[i]  <= '0;
        vel_q[i]  <= '0;
        psum_q[i] <= '0;
        tgt_q[i]  <= '0;
        sep_q[i]  <= '0;
        sk_q[i]   <= '0;
      end
      s_q     <= '0;
      acc_q   <= '0;
      lsq_q   <= '0;
      n_q     <= '0;
      len_q   <= '0;
      pcnt_q  <= '0;
      near_q  <= NearInit;
      seen_q  <= 1'b0;
      res_q   <= '0;
      oval_q  <= 1'b0;
      ms_q    <= 24'd1310720;
      mf_q    <= 24'd6554;
      rad_q   <= 24'd786432;
      sgain_q <= 25'sd65536;
      kgain_q <= 25'sd65536;
      prod_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      ph_q    <= ph_d;
      idx_q   <= idx_d;
      v_q     <= v_d;
      m_q     <= m_d;
      p_q     <= p_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      psum_q  <= psum_d;
      tgt_q   <= tgt_d;
      sep_q   <= sep_d;
      sk_q    <= sk_d;
      s_q     <= s_d;
      acc_q   <= acc_d;
      lsq_q   <= lsq_d;
      n_q     <= n_d;
      len_q   <= len_d;
      pcnt_q  <= pcnt_d;
      near_q  <= near_d;
      seen_q  <= seen_d;
      res_q   <= res_d;
      oval_q  <= oval_d;
      ms_q    <= ms_d;
      mf_q    <= mf_d;
      rad_q   <= rad_d;
      sgain_q <= sgain_d;
      kgain_q <= kgain_d;
      prod_q  <= 64'(mul_a) * 64'(mul_b);
    end
  end

endmodule
